>>> hw/rtl/frc_pkg.sv
// shared types and constants for the frame receive checker
`default_nettype none

package frc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CfgFrameId  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCapacity = CfgIdxW'(1);

  localparam logic [ByteW-1:0] FrameIdRst  = '0;
  localparam logic [LenW-1:0]  CapacityRst = '1;

  typedef enum logic [1:0] {
    PhId   = 2'd0,
    PhLen  = 2'd1,
    PhData = 2'd2,
    PhSum  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StBusy   = 3'd0,
    StOk     = 3'd1,
    StBadId  = 3'd2,
    StBadLen = 3'd3,
    StBadSum = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic                payload_valid;
    logic [ByteW-1:0]    payload_byte;
    logic [LenW-1:0]     payload_index;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/frame_receive_checker.sv
// top level of the frame receive checker
//
// Takes one received link byte per input beat on in_valid_i/in_ready_o and
// returns exactly one result beat per input byte on out_valid_o/out_ready_i:
// a status (busy, frame ok, bad id, bad length, bad checksum) plus, for
// payload bytes, the byte and its index inside the payload.
// Frame format: id byte, 16-bit length low byte first, payload, checksum
// equal to the payload sum mod 256. Any error or finished frame goes back to
// waiting for an id byte.
// The result of a byte is registered at the edge that takes it. Throughput is
// one byte per cycle while in_ready_o is high, limited by the single parser
// state update per byte.
// The output register is backed by a one-beat skid stage, so in_ready_o is
// registered; a stalled receiver holds up to two results before in_ready_o
// drops.
// Reset clears the parser to id wait, sets frame_id to 0 and capacity to
// 65535. cfg_ready_o is tied high, so register writes are always accepted;
// index 0 is frame_id, 1 is payload_capacity, others are ignored.
`default_nettype none

module frame_receive_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [frc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [frc_pkg::CfgW-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [frc_pkg::ByteW-1:0]    wire_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [2:0]                   status_o,
  output logic                         payload_valid_o,
  output logic [frc_pkg::ByteW-1:0]    payload_byte_o,
  output logic [frc_pkg::LenW-1:0]     payload_index_o
);

  logic [frc_pkg::ByteW-1:0] frame_id_q;
  logic [frc_pkg::LenW-1:0]  capacity_q;
  logic                      beat;
  frc_pkg::result_t          core_result;
  frc_pkg::result_t          out_result;

  assign cfg_ready_o = 1'b1;
  assign beat        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q <= frc_pkg::FrameIdRst;
      capacity_q <= frc_pkg::CapacityRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        frc_pkg::CfgFrameId:  frame_id_q <= cfg_data_i[frc_pkg::ByteW-1:0];
        frc_pkg::CfgCapacity: capacity_q <= cfg_data_i[frc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  frc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .wire_byte_i (wire_byte_i),
    .frame_id_i  (frame_id_q),
    .capacity_i  (capacity_q),
    .result_o    (core_result)
  );

  frc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (core_result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_result)
  );

  assign status_o        = out_result.status;
  assign payload_valid_o = out_result.payload_valid;
  assign payload_byte_o  = out_result.payload_byte;
  assign payload_index_o = out_result.payload_index;

endmodule

`default_nettype wire

>>> hw/rtl/frc_core.sv
// frame parser state machine and per-byte result logic
`default_nettype none

module frc_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         beat_i,
  input  wire  [frc_pkg::ByteW-1:0]   wire_byte_i,
  input  wire  [frc_pkg::ByteW-1:0]   frame_id_i,
  input  wire  [frc_pkg::LenW-1:0]    capacity_i,
  output frc_pkg::result_t            result_o
);

  frc_pkg::phase_e             phase_q, phase_d;
  logic                        len_high_q, len_high_d;
  logic [frc_pkg::LenW-1:0]    frame_length_q, frame_length_d;
  logic [frc_pkg::LenW-1:0]    bytes_taken_q, bytes_taken_d;
  logic [frc_pkg::ByteW-1:0]   running_sum_q, running_sum_d;
  logic [frc_pkg::LenW-1:0]    full_length;
  logic [frc_pkg::LenW-1:0]    bytes_inc;

  // low byte already sits in frame_length_q when the high byte arrives
  assign full_length = {wire_byte_i, frame_length_q[frc_pkg::ByteW-1:0]};
  assign bytes_inc   = bytes_taken_q + frc_pkg::LenW'(1);

  // next state
  always_comb begin
    phase_d        = phase_q;
    len_high_d     = len_high_q;
    frame_length_d = frame_length_q;
    bytes_taken_d  = bytes_taken_q;
    running_sum_d  = running_sum_q;
    case (phase_q)
      frc_pkg::PhId: begin
        phase_d        = (wire_byte_i == frame_id_i) ? frc_pkg::PhLen : frc_pkg::PhId;
        len_high_d     = 1'b0;
        frame_length_d = '0;
        bytes_taken_d  = '0;
        running_sum_d  = '0;
      end
      frc_pkg::PhLen: begin
        if (!len_high_q) begin
          frame_length_d = {{(frc_pkg::LenW-frc_pkg::ByteW){1'b0}}, wire_byte_i};
          len_high_d     = 1'b1;
        end else begin
          len_high_d    = 1'b0;
          bytes_taken_d = '0;
          running_sum_d = '0;
          if (full_length <= capacity_i) begin
            frame_length_d = full_length;
            phase_d = (full_length == '0) ? frc_pkg::PhSum : frc_pkg::PhData;
          end else begin
            frame_length_d = '0;
            phase_d        = frc_pkg::PhId;
          end
        end
      end
      frc_pkg::PhData: begin
        running_sum_d = running_sum_q + wire_byte_i;
        bytes_taken_d = bytes_inc;
        if (bytes_inc >= frame_length_q) begin
          phase_d = frc_pkg::PhSum;
        end
      end
      default: begin
        phase_d        = frc_pkg::PhId;
        len_high_d     = 1'b0;
        frame_length_d = '0;
        bytes_taken_d  = '0;
        running_sum_d  = '0;
      end
    endcase
  end

  // per-byte result
  always_comb begin
    result_o = '{status: frc_pkg::StBusy, payload_valid: 1'b0,
                 payload_byte: '0, payload_index: '0};
    case (phase_q)
      frc_pkg::PhId: begin
        if (wire_byte_i != frame_id_i) begin
          result_o.status = frc_pkg::StBadId;
        end
      end
      frc_pkg::PhLen: begin
        if (len_high_q && (full_length > capacity_i)) begin
          result_o.status = frc_pkg::StBadLen;
        end
      end
      frc_pkg::PhData: begin
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = wire_byte_i;
        result_o.payload_index = bytes_taken_q;
      end
      default: begin
        result_o.status = (wire_byte_i == running_sum_q) ? frc_pkg::StOk : frc_pkg::StBadSum;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= frc_pkg::PhId;
      len_high_q     <= 1'b0;
      frame_length_q <= '0;
      bytes_taken_q  <= '0;
      running_sum_q  <= '0;
    end else if (beat_i) begin
      phase_q        <= phase_d;
      len_high_q     <= len_high_d;
      frame_length_q <= frame_length_d;
      bytes_taken_q  <= bytes_taken_d;
      running_sum_q  <= running_sum_d;
    end
  end

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == frc_pkg::PhData) |-> (bytes_taken_q < frame_length_q))
    else $error("payload count reached length while still in data phase");

  a_len_flag_only_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != frc_pkg::PhLen) |-> !len_high_q)
    else $error("high length flag set outside length phase");

  a_end_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && (result_o.status != frc_pkg::StBusy)) |=> (phase_q == frc_pkg::PhId))
    else $error("frame end or error did not return to id wait");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == frc_pkg::PhId) |-> ((bytes_taken_q == '0) && (running_sum_q == '0)))
    else $error("stale count or sum while waiting for id");

endmodule

`default_nettype wire

>>> hw/rtl/frc_skid.sv
// output register with skid stage so the input side sees a registered ready
`default_nettype none

module frc_skid (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire frc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output frc_pkg::result_t  out_data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  frc_pkg::result_t out_data_q;
  frc_pkg::result_t skid_data_q;
  logic             push;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (push) begin
      skid_data_q <= in_data_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push)
    else $error("beat taken while skid stage is full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid beat not moved to output register");

endmodule

`default_nettype wire
